[hdl/lru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// shared types and constants of the lru page replacement core
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 20;

    localparam int CFG_W     = 5;
    localparam int FIDX_OUT_W = 4;
    localparam int RANK_W    = 4;
    localparam int FAULT_W   = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

[hdl/lru_page_replacement_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// fully associative page frame table with least recently used replacement
// ----------------------------------------------------------------------------
// Usage:
//   slave stream s_t*: one beat is one page reference, page in the low bits
//   of s_tdata. master stream m_t*: one result beat per reference with the
//   hit flag, the frame that holds the page, the eviction flag and page and
//   the saturating fault count.
//   i_cfg_we / i_cfg_wdata write frames_in_use (0 acts as 1, values above
//   FRAMES act as FRAMES); write it only while the core is idle.
// Timing:
//   after the accepting edge the shared compare unit scans one active frame
//   per cycle (a hit stops the scan, a miss scans every active frame), then
//   the update state loads the result. The next beat can be accepted in the
//   cycle after the result has been delivered.
// Reset:
//   synchronous, active low: all frames free, ranks zero, fault count zero,
//   frames_in_use back to 3. No clearing pass is needed.
// Stall:
//   while m_tready is low the result holds and s_tready stays low.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
    localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 1 + lru_pkg::FIDX_OUT_W + 1 + PAGE_BITS + lru_pkg::FAULT_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lru_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_W-1:0]           s_tdata,   // page
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_W-1:0]          m_tdata    // hit, frame_index, evicted, evicted_page,
                                                 // fault_count
);

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int O_FIDX = 1;
    localparam int O_EV   = O_FIDX + lru_pkg::FIDX_OUT_W;
    localparam int O_EVP  = O_EV + 1;
    localparam int O_FLT  = O_EVP + PAGE_BITS;

    typedef logic [lru_pkg::RANK_W-1:0] t_rank;

    lru_pkg::t_state r_state, n_state;

    logic [lru_pkg::CFG_W-1:0]   r_cfg;
    logic [PAGE_BITS-1:0]        r_page [FRAMES];
    logic [FRAMES-1:0]           r_valid, n_valid;
    t_rank                       r_rank [FRAMES];
    t_rank                       n_rank [FRAMES];
    logic [PAGE_BITS-1:0]        r_key, n_key;
    logic [FIDX_W-1:0]           r_idx, n_idx;
    logic [FIDX_W-1:0]           r_last, n_last;
    logic                        r_hit, n_hit;
    logic                        r_free_found, n_free_found;
    logic [FIDX_W-1:0]           r_free, n_free;
    logic                        r_any, n_any;
    t_rank                       r_best, n_best;
    logic [FIDX_W-1:0]           r_vic, n_vic;
    logic [lru_pkg::FAULT_W-1:0] r_fault, n_fault;
    logic                        r_out_valid, n_out_valid;
    logic [OUT_W-1:0]            r_out_data, n_out_data;
    logic                        page_we;

    logic [lru_pkg::CFG_W-1:0]   act_cnt;
    logic                        cur_valid;
    logic                        cur_match;
    logic                        fill;
    logic                        evict;

    assign s_tready = (r_state == lru_pkg::ST_IDLE) && !r_out_valid;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    always_comb begin
        if (r_cfg == '0) begin
            act_cnt = lru_pkg::CFG_W'(1);
        end else if (r_cfg > lru_pkg::CFG_W'(FRAMES)) begin
            act_cnt = lru_pkg::CFG_W'(FRAMES);
        end else begin
            act_cnt = r_cfg;
        end
    end

    assign cur_valid = r_valid[r_idx];
    assign cur_match = cur_valid && (r_page[r_idx] == r_key);
    assign fill      = !r_hit && r_free_found;
    assign evict     = !r_hit && !r_free_found;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_rank       = r_rank;
        n_key        = r_key;
        n_idx        = r_idx;
        n_last       = r_last;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_any        = r_any;
        n_best       = r_best;
        n_vic        = r_vic;
        n_fault      = r_fault;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        page_we      = 1'b0;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lru_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    n_key        = s_tdata[PAGE_BITS-1:0];
                    n_idx        = '0;
                    n_last       = FIDX_W'(act_cnt - lru_pkg::CFG_W'(1));
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_free       = '0;
                    n_any        = 1'b0;
                    n_best       = '0;
                    n_vic        = '0;
                    n_state      = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN: begin
                if (cur_match) begin
                    n_hit   = 1'b1;
                    n_state = lru_pkg::ST_UPDATE;
                end else begin
                    if (!cur_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = r_idx;
                    end
                    if (cur_valid && (!r_any || r_rank[r_idx] > r_best)) begin
                        n_any  = 1'b1;
                        n_best = r_rank[r_idx];
                        n_vic  = r_idx;
                    end
                    if (r_idx == r_last) begin
                        n_idx   = n_free_found ? n_free : n_vic;
                        n_state = lru_pkg::ST_UPDATE;
                    end else begin
                        n_idx = r_idx + FIDX_W'(1);
                    end
                end
            end
            lru_pkg::ST_UPDATE: begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (FIDX_W'(i) == r_idx) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (fill || r_rank[i] < r_rank[r_idx])
                                 && r_rank[i] != '1) begin
                        n_rank[i] = r_rank[i] + t_rank'(1);
                    end
                end
                n_valid[r_idx] = 1'b1;
                page_we        = !r_hit;
                if (!r_hit && r_fault != '1) begin
                    n_fault = r_fault + lru_pkg::FAULT_W'(1);
                end
                n_out_data = '0;
                n_out_data[0] = r_hit;
                n_out_data[O_FIDX +: lru_pkg::FIDX_OUT_W] = lru_pkg::FIDX_OUT_W'(r_idx);
                n_out_data[O_EV] = evict;
                n_out_data[O_EVP +: PAGE_BITS] = evict ? r_page[r_idx] : '0;
                n_out_data[O_FLT +: lru_pkg::FAULT_W] = n_fault;
                n_out_valid = 1'b1;
                n_state     = lru_pkg::ST_IDLE;
            end
            default: begin
                n_state = lru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lru_pkg::ST_IDLE;
            r_cfg       <= lru_pkg::CFG_RESET;
            r_valid     <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
            r_rank      <= n_rank;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_hit        <= n_hit;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_any        <= n_any;
        r_best       <= n_best;
        r_vic        <= n_vic;
        r_out_data   <= n_out_data;
        if (page_we) begin
            r_page[r_idx] <= r_key;
        end
    end

    // update always leaves a result behind
    a_update_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::ST_UPDATE) |=> r_out_valid)
        else $error("update did not load result");

    // the touched frame becomes valid and most recent
    a_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::ST_UPDATE) |=>
            (r_valid[$past(r_idx)] && r_rank[$past(r_idx)] == '0))
        else $error("touched frame not most recent");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[O_EV]))
        else $error("hit and evict together");

    // fault count never goes down
    a_fault_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fault >= $past(r_fault)))
        else $error("fault count decreased");

    // no new beat while a result is still pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !s_tready)
        else $error("accept with pending result");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru page replacement core
// ----------------------------------------------------------------------------
// Drives page references on the slave stream and takes results from the
// master stream. Both sides insert random gaps. A scoreboard class keeps its
// own copy of the frame table, ranks and fault count, and predicts each
// result from every accepted reference. Stimulus is a short directed run
// followed by random phases under different frame counts, with pages drawn
// mostly from a small working set so that hits and evictions are frequent.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PAGE_W     = lru_pkg::PAGE_BITS_DEF;
    localparam int NFRAMES    = lru_pkg::FRAMES_DEF;
    localparam int IN_W       = ((PAGE_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + lru_pkg::FIDX_OUT_W + 1 + PAGE_W + lru_pkg::FAULT_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
    localparam int QUIET_MAX  = 2000;
    localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

    // packed from the top down so that hit lands in bit 0
    typedef struct packed {
        logic [lru_pkg::FAULT_W-1:0]    fault_count;
        logic [PAGE_W-1:0]              evicted_page;
        logic                           evicted;
        logic [lru_pkg::FIDX_OUT_W-1:0] frame_index;
        logic                           hit;
    } t_ref_result;

    class page_ref_scoreboard;
        logic [PAGE_W-1:0]          frame_page [NFRAMES];
        bit                         frame_valid [NFRAMES];
        int unsigned                rank [NFRAMES];
        int unsigned                filled;
        logic [lru_pkg::FAULT_W-1:0] faults;
        logic [lru_pkg::CFG_W-1:0]  frames_cfg;
        t_ref_result                expected_q [$];
        int unsigned                errors;

        function new();
            for (int i = 0; i < NFRAMES; i++) begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                rank[i]        = 0;
            end
            filled     = 0;
            faults     = '0;
            frames_cfg = lru_pkg::CFG_RESET;
            errors     = 0;
        endfunction

        function void set_frames(logic [lru_pkg::CFG_W-1:0] v);
            frames_cfg = v;
        endfunction

        function int active_frames();
            int n;
            n = frames_cfg;
            if (n < 1) n = 1;
            if (n > NFRAMES) n = NFRAMES;
            return n;
        endfunction

        // frame f becomes most recent, younger valid frames age by one
        function void promote(int f, int unsigned limit);
            for (int i = 0; i < NFRAMES; i++) begin
                if (i != f && frame_valid[i] && rank[i] < limit && rank[i] < 15)
                    rank[i]++;
            end
            rank[f] = 0;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] page);
            t_ref_result r;
            int          n;
            int          f;
            bit          found;
            bit          any;
            int unsigned oldest;
            r     = '0;
            n     = active_frames();
            f     = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (frame_valid[i] && frame_page[i] == page) begin
                    found = 1'b1;
                    f     = i;
                    break;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                promote(f, rank[f]);
            end else begin
                if (faults != '1) faults++;
                for (int i = 0; i < n; i++) begin
                    if (!frame_valid[i]) begin
                        found = 1'b1;
                        f     = i;
                        break;
                    end
                end
                if (found) begin
                    promote(f, 16);
                    frame_valid[f] = 1'b1;
                    frame_page[f]  = page;
                    if (filled < NFRAMES) filled++;
                end else begin
                    any    = 1'b0;
                    oldest = 0;
                    for (int i = 0; i < n; i++) begin
                        if (frame_valid[i] && (!any || rank[i] > oldest)) begin
                            any    = 1'b1;
                            oldest = rank[i];
                            f      = i;
                        end
                    end
                    r.evicted      = 1'b1;
                    r.evicted_page = frame_page[f];
                    promote(f, rank[f]);
                    frame_page[f] = page;
                end
            end
            r.frame_index = f[lru_pkg::FIDX_OUT_W-1:0];
            r.fault_count = faults;
            expected_q = {expected_q, r};
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_ref_result got;
            t_ref_result want;
            got = data[OUT_BITS-1:0];
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: %h", data);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.frame_index !== want.frame_index) begin
                $error("frame_index: expected %0d, got %0d", want.frame_index, got.frame_index);
                errors++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_page !== want.evicted_page) begin
                $error("evicted_page: expected %h, got %h", want.evicted_page, got.evicted_page);
                errors++;
            end
            if (got.fault_count !== want.fault_count) begin
                $error("fault_count: expected %0d, got %0d", want.fault_count, got.fault_count);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [lru_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata = '0;   // page
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_W-1:0]          m_tdata;        // hit, frame_index, evicted, evicted_page,
                                               // fault_count

    page_ref_scoreboard sb = new();
    bit                 rx_idle_on = 1'b1;
    int unsigned        quiet_cycles = 0;
    logic [PAGE_W-1:0]  pool [32];

    lru_page_replacement_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // valid stays high into the next beat when there is no gap
    task automatic send_page(input logic [PAGE_W-1:0] page, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(page);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_reference(page);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [lru_pkg::CFG_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_frames(v);
    endtask

    task automatic run_phase(input logic [lru_pkg::CFG_W-1:0] frames, input int count,
                             input bit tx_idle, input bit rx_idle, input bit mid_pause);
        int                span;
        logic [PAGE_W-1:0] page;
        write_frames(frames);
        rx_idle_on = rx_idle;
        span = sb.active_frames();
        span = span + span / 2 + 2;
        if (span > 31) span = 31;
        for (int k = 0; k < 8; k++)
            pool[$urandom_range(0, 31)] = PAGE_W'($urandom_range(0, PAGE_MAX));
        for (int k = 0; k < count; k++) begin
            if (mid_pause && k == count / 2) wait_drained();
            if ($urandom_range(0, 99) < 85)
                page = pool[$urandom_range(0, span)];
            else
                page = PAGE_W'($urandom_range(0, PAGE_MAX));
            send_page(page, tx_idle ? $urandom_range(0, 15) : 0);
        end
    endtask

    // result side
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < 32; i++) pool[i] = PAGE_W'($urandom_range(0, PAGE_MAX));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill and evict under the reset frame count
        send_page(20'h00000, $urandom_range(0, 15));
        send_page(PAGE_MAX, $urandom_range(0, 15));
        send_page(20'h00000, $urandom_range(0, 15));
        send_page(20'h5A5A5, $urandom_range(0, 15));
        send_page(20'hA5A5A, $urandom_range(0, 15));
        send_page(PAGE_MAX, $urandom_range(0, 15));
        // zero frames acts as one, the page also sits in an inactive frame
        write_frames(5'd0);
        send_page(20'h5A5A5, $urandom_range(0, 15));
        send_page(20'h5A5A5, $urandom_range(0, 15));
        // above the frame count acts as all frames, duplicate hits lowest index
        write_frames(5'd31);
        send_page(20'h5A5A5, $urandom_range(0, 15));
        send_page(20'hA5A5A, $urandom_range(0, 15));
        send_page(PAGE_MAX, 0);
        send_page(20'h00001, 0);
        send_page(20'h80000, 0);
        send_page(20'h7FFFF, $urandom_range(0, 15));
        send_page(20'h0A0A0, 0);
        send_page(20'h00000, $urandom_range(0, 15));
        write_frames(5'd16);
        send_page(20'h5A5A5, $urandom_range(0, 15));
        send_page(20'h12345, 0);

        run_phase(5'd1,  65, 1'b1, 1'b1, 1'b0);
        run_phase(5'd16, 65, 1'b0, 1'b0, 1'b0);
        run_phase(5'd2,  65, 1'b1, 1'b0, 1'b0);
        run_phase(5'd17, 65, 1'b0, 1'b1, 1'b0);
        run_phase(5'd5,  65, 1'b1, 1'b1, 1'b1);
        run_phase(5'd31, 65, 1'b1, 1'b1, 1'b0);
        run_phase(5'd8,  65, 1'b0, 1'b0, 1'b0);
        run_phase(5'd0,  65, 1'b1, 1'b0, 1'b0);
        run_phase(5'd12, 65, 1'b0, 1'b1, 1'b0);
        run_phase(5'd4,  65, 1'b1, 1'b1, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
